@@ rtl/core/rwlf_pkg.sv @@
// Shared types and constants of the regularized weighted line fit.
// Depends on nothing; every other file of the block imports it.
package rwlf_pkg;

  localparam int WEIGHT_W   = 13;
  localparam int DEPTH_W    = 15;
  localparam int OUT_W      = 24;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int SW_W       = 29;
  localparam int SWX_W      = 44;
  localparam int SWXX_W     = 59;
  localparam int CNT_W      = 17;
  localparam int WX_W       = WEIGHT_W + DEPTH_W;
  localparam int WXX_W      = WX_W + DEPTH_W;
  localparam int MUL_W      = 64;
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic [CNT_W-1:0] MAX_POINTS = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_BIAS  = 2'd1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FEW      = 2'd1;
  localparam logic [1:0] STATUS_SINGULAR = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  localparam logic [OUT_W-1:0] LIM_POS = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] LIM_NEG = 24'h800000;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [DEPTH_W-1:0]  depth_x;
    logic [DEPTH_W-1:0]  depth_y;
    logic                last;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] scale;
    logic signed [OUT_W-1:0] bias;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic [SW_W-1:0]   sw;
    logic [SWX_W-1:0]  swx;
    logic [SWX_W-1:0]  swy;
    logic [SWXX_W-1:0] swxx;
    logic [SWXX_W-1:0] swxy;
    logic [CNT_W-1:0]  count;
    logic              ovf;
  } rwlf_sums_t;

endpackage

@@ rtl/core/regularized_weighted_line_fit.sv @@
// Regularized weighted line fit, top level: accumulator, solve sequencer, output register.
// Depends on rwlf_pkg, rwlf_accum, rwlf_mul and rwlf_div.
// Flow: a point passes through the bit-serial accumulator (two 15-bit passes plus one add);
// the next point is taken when that, and any solve it starts, is done. A last point adds the
// solve: six products and two divisions, then the result goes to the output register. Reset
// (rst_n low, synchronous) clears sums, count, overflow flag, ridge weights and valid.
module regularized_weighted_line_fit import rwlf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_MULW  = 4'd4;
  localparam logic [3:0] S_DET   = 4'd5;
  localparam logic [3:0] S_SGN   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DIVW  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [2:0] LAST_PROD = 3'd5;

  logic [3:0]          st_r, st_nxt;
  logic [CFG_W-1:0]    lscale_r, lbias_r;
  logic                last_r, last_nxt;
  logic [SWXX_W:0]     a11_r, a11_nxt, b1_r, b1_nxt;
  logic [SWX_W-1:0]    a12_r, a12_nxt, b2_r, b2_nxt;
  logic [SW_W+3:0]     a22_r, a22_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [PROD_W-1:0]   prod_r [6];
  logic                j_r, j_nxt, neg_r, neg_nxt, sat_r, sat_nxt;
  logic [PROD_W-1:0]   det_r, det_nxt, mag_r, mag_nxt;
  logic [OUT_W-1:0]    scale_r, scale_nxt, bias_r, bias_nxt, lim, val, res;
  logic [1:0]          stat_r, stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;
  logic [PROD_W-1:0]   sp, sm;
  logic                acc_start, acc_clear, acc_done;
  rwlf_sums_t          sums;
  logic                mul_start, mul_done, div_start, div_done;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p, div_q, div_num;

  // Accept points only while the sequencer is free; a finished result may still wait.
  assign in_ready  = (st_r == S_IDLE);
  assign acc_start = in_valid && in_ready;
  assign acc_clear = (st_r == S_CHECK);

  rwlf_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (acc_start),
    .weight (in_data.weight),
    .xin    (in_data.depth_x),
    .yin    (in_data.depth_y),
    .clear  (acc_clear),
    .done   (acc_done),
    .sums   (sums)
  );

  // Operand pairs of the six products: d1, d2, scale numerator terms, bias numerator terms.
  always_comb begin
    unique case (k_r)
      3'd0: begin mul_a = MUL_W'(a11_r); mul_b = MUL_W'(a22_r); end
      3'd1: begin mul_a = MUL_W'(a12_r); mul_b = MUL_W'(a12_r); end
      3'd2: begin mul_a = MUL_W'(b1_r);  mul_b = MUL_W'(a22_r); end
      3'd3: begin mul_a = MUL_W'(a12_r); mul_b = MUL_W'(b2_r);  end
      3'd4: begin mul_a = MUL_W'(a11_r); mul_b = MUL_W'(b2_r);  end
      default: begin mul_a = MUL_W'(b1_r); mul_b = MUL_W'(a12_r); end
    endcase
  end

  assign mul_start = (st_r == S_MUL);

  rwlf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Round half away from zero: add half the determinant to the magnitude.
  assign div_num   = mag_r + (det_r >> 1);
  assign div_start = (st_r == S_DIV);

  rwlf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // Scale terms carry 16 fraction bits; bias terms are used as they are.
  assign sp  = j_r ? prod_r[4] : (prod_r[2] << 16);
  assign sm  = j_r ? prod_r[5] : (prod_r[3] << 16);
  assign lim = neg_r ? LIM_NEG : LIM_POS;
  assign val = (div_q > {{(PROD_W-OUT_W){1'b0}}, lim}) ? lim : div_q[OUT_W-1:0];
  assign res = neg_r ? (OUT_W'(0) - val) : val;

  always_comb begin
    st_nxt        = st_r;
    last_nxt      = last_r;
    a11_nxt       = a11_r;
    a12_nxt       = a12_r;
    a22_nxt       = a22_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    det_nxt       = det_r;
    mag_nxt       = mag_r;
    scale_nxt     = scale_r;
    bias_nxt      = bias_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    // Drop the waiting result once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (st_r)
      S_IDLE: begin
        if (acc_start) begin
          last_nxt = in_data.last;
          st_nxt   = S_ACC;
        end
      end
      S_ACC: begin
        if (acc_done) begin
          st_nxt = last_r ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        // Latch the normal-equation terms; the accumulator clears at this edge.
        a11_nxt   = {1'b0, sums.swxx} + {{(SWXX_W+1-CFG_W){1'b0}}, lscale_r};
        b1_nxt    = {1'b0, sums.swxy} + {{(SWXX_W+1-CFG_W){1'b0}}, lscale_r};
        a22_nxt   = {4'b0, sums.sw} + {{(SW_W+4-CFG_W){1'b0}}, lbias_r};
        a12_nxt   = sums.swx;
        b2_nxt    = sums.swy;
        scale_nxt = '0;
        bias_nxt  = '0;
        k_nxt     = '0;
        if (sums.count < 17'd2) begin
          stat_nxt = STATUS_FEW;
          st_nxt   = S_OUT;
        end else if (sums.ovf) begin
          stat_nxt = STATUS_OVERFLOW;
          st_nxt   = S_OUT;
        end else begin
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        st_nxt = S_MULW;
      end
      S_MULW: begin
        if (mul_done) begin
          if (k_r == LAST_PROD) begin
            st_nxt = S_DET;
          end else begin
            k_nxt  = k_r + 3'd1;
            st_nxt = S_MUL;
          end
        end
      end
      S_DET: begin
        if (prod_r[0] <= prod_r[1]) begin
          stat_nxt = STATUS_SINGULAR;
          st_nxt   = S_OUT;
        end else begin
          det_nxt = prod_r[0] - prod_r[1];
          j_nxt   = 1'b0;
          sat_nxt = 1'b0;
          st_nxt  = S_SGN;
        end
      end
      S_SGN: begin
        neg_nxt = (sp < sm);
        mag_nxt = (sp < sm) ? (sm - sp) : (sp - sm);
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        st_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          if (div_q > {{(PROD_W-OUT_W){1'b0}}, lim}) begin
            sat_nxt = 1'b1;
          end
          if (j_r) begin
            bias_nxt = res;
            stat_nxt = (sat_r || (div_q > {{(PROD_W-OUT_W){1'b0}}, lim})) ?
                       STATUS_OVERFLOW : STATUS_OK;
            st_nxt   = S_OUT;
          end else begin
            scale_nxt = res;
            j_nxt     = 1'b1;
            st_nxt    = S_SGN;
          end
        end
      end
      S_OUT: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.scale  = $signed(scale_r);
          out_data_nxt.bias   = $signed(bias_r);
          out_data_nxt.status = stat_r;
          out_valid_nxt       = 1'b1;
          st_nxt              = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      lscale_r    <= '0;
      lbias_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_addr == REG_LAMBDA_SCALE) begin
        lscale_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == REG_LAMBDA_BIAS) begin
        lbias_r <= cfg_wdata;
      end
    end
    last_r     <= last_nxt;
    a11_r      <= a11_nxt;
    a12_r      <= a12_nxt;
    a22_r      <= a22_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    neg_r      <= neg_nxt;
    sat_r      <= sat_nxt;
    det_r      <= det_nxt;
    mag_r      <= mag_nxt;
    scale_r    <= scale_nxt;
    bias_r     <= bias_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
    if (st_r == S_MULW && mul_done) begin
      prod_r[k_r] <= mul_p;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/rwlf_accum.sv @@
// Point accumulator: bit-serial products w*x, w*y, w*x*x, w*x*y and saturating sums.
// Depends on rwlf_pkg.
module rwlf_accum import rwlf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [DEPTH_W-1:0]  xin,
  input  logic [DEPTH_W-1:0]  yin,
  input  logic                clear,
  output logic                done,
  output rwlf_sums_t          sums
);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL1 = 2'd1;
  localparam logic [1:0] A_MUL2 = 2'd2;
  localparam logic [1:0] A_ADD  = 2'd3;
  localparam logic [3:0] LAST_BIT = 4'(DEPTH_W - 1);

  logic [1:0]          st_r, st_nxt;
  logic [3:0]          bit_r, bit_nxt;
  logic [DEPTH_W-1:0]  x_r, x_nxt, y_r, y_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [WXX_W-1:0]    mc_r, mc_nxt, px_r, px_nxt, py_r, py_nxt;
  logic [WXX_W-1:0]    px_add, py_add;
  logic [WX_W-1:0]     wx_r, wx_nxt, wy_r, wy_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  rwlf_sums_t          sums_r, sums_nxt;
  logic                done_r, done_nxt;
  logic [SW_W:0]       s_w;
  logic [SWX_W:0]      s_wx, s_wy;
  logic [SWXX_W:0]     s_wxx, s_wxy;

  assign px_add = px_r + (sx_r[0] ? mc_r : '0);
  assign py_add = py_r + (sy_r[0] ? mc_r : '0);
  assign s_w    = {1'b0, sums_r.sw} + {{(SW_W+1-WEIGHT_W){1'b0}}, w_r};
  assign s_wx   = {1'b0, sums_r.swx} + {{(SWX_W+1-WX_W){1'b0}}, wx_r};
  assign s_wy   = {1'b0, sums_r.swy} + {{(SWX_W+1-WX_W){1'b0}}, wy_r};
  assign s_wxx  = {1'b0, sums_r.swxx} + {{(SWXX_W+1-WXX_W){1'b0}}, px_r};
  assign s_wxy  = {1'b0, sums_r.swxy} + {{(SWXX_W+1-WXX_W){1'b0}}, py_r};

  always_comb begin
    st_nxt   = st_r;
    bit_nxt  = bit_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    mc_nxt   = mc_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    wx_nxt   = wx_r;
    wy_nxt   = wy_r;
    w_nxt    = w_r;
    sums_nxt = sums_r;
    done_nxt = 1'b0;
    unique case (st_r)
      A_IDLE: begin
        if (clear) begin
          sums_nxt = '0;
        end
        if (start) begin
          w_nxt   = weight;
          x_nxt   = xin;
          y_nxt   = yin;
          sx_nxt  = xin;
          sy_nxt  = yin;
          mc_nxt  = {{(WXX_W-WEIGHT_W){1'b0}}, weight};
          px_nxt  = '0;
          py_nxt  = '0;
          bit_nxt = '0;
          st_nxt  = A_MUL1;
        end
      end
      A_MUL1: begin
        px_nxt  = px_add;
        py_nxt  = py_add;
        sx_nxt  = sx_r >> 1;
        sy_nxt  = sy_r >> 1;
        mc_nxt  = mc_r << 1;
        bit_nxt = bit_r + 4'd1;
        if (bit_r == LAST_BIT) begin
          // w*x and w*y are done: reload for the second pass with w*x as multiplicand
          wx_nxt  = px_add[WX_W-1:0];
          wy_nxt  = py_add[WX_W-1:0];
          mc_nxt  = {{(WXX_W-WX_W){1'b0}}, px_add[WX_W-1:0]};
          px_nxt  = '0;
          py_nxt  = '0;
          sx_nxt  = x_r;
          sy_nxt  = y_r;
          bit_nxt = '0;
          st_nxt  = A_MUL2;
        end
      end
      A_MUL2: begin
        px_nxt  = px_add;
        py_nxt  = py_add;
        sx_nxt  = sx_r >> 1;
        sy_nxt  = sy_r >> 1;
        mc_nxt  = mc_r << 1;
        bit_nxt = bit_r + 4'd1;
        if (bit_r == LAST_BIT) begin
          st_nxt = A_ADD;
        end
      end
      A_ADD: begin
        sums_nxt.sw   = s_w[SW_W] ? '1 : s_w[SW_W-1:0];
        sums_nxt.swx  = s_wx[SWX_W] ? '1 : s_wx[SWX_W-1:0];
        sums_nxt.swy  = s_wy[SWX_W] ? '1 : s_wy[SWX_W-1:0];
        sums_nxt.swxx = s_wxx[SWXX_W] ? '1 : s_wxx[SWXX_W-1:0];
        sums_nxt.swxy = s_wxy[SWXX_W] ? '1 : s_wxy[SWXX_W-1:0];
        if (sums_r.count >= MAX_POINTS) begin
          sums_nxt.count = MAX_POINTS;
        end else begin
          sums_nxt.count = sums_r.count + 17'd1;
        end
        sums_nxt.ovf = sums_r.ovf | s_w[SW_W] | s_wx[SWX_W] | s_wy[SWX_W] |
                       s_wxx[SWXX_W] | s_wxy[SWXX_W] | (sums_r.count >= MAX_POINTS);
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      sums_r <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      sums_r <= sums_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    mc_r  <= mc_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    wx_r  <= wx_nxt;
    wy_r  <= wy_nxt;
    w_r   <= w_nxt;
  end

  assign done = done_r;
  assign sums = sums_r;

endmodule

@@ rtl/core/rwlf_mul.sv @@
// Bit-serial shift-add multiplier, 64 x 64 to 128 bits, one multiplier bit per cycle.
// Depends on rwlf_pkg.
module rwlf_mul import rwlf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] p
);

  logic [PROD_W-1:0] mc_r, mc_nxt, p_r, p_nxt;
  logic [MUL_W-1:0]  mb_r, mb_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    mc_nxt   = mc_r;
    p_nxt    = p_r;
    mb_nxt   = mb_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      p_nxt   = p_r + (mb_r[0] ? mc_r : '0);
      mc_nxt  = mc_r << 1;
      mb_nxt  = mb_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(MUL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      mc_nxt   = {{MUL_W{1'b0}}, a};
      mb_nxt   = b;
      p_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mc_r  <= mc_nxt;
    p_r   <= p_nxt;
    mb_r  <= mb_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

@@ rtl/core/rwlf_div.sv @@
// Restoring divider, 128 by 128 bits, one quotient bit per cycle.
// Depends on rwlf_pkg.
module rwlf_div import rwlf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [PROD_W-1:0] den,
  output logic              done,
  output logic [PROD_W-1:0] quo
);

  logic [PROD_W-1:0] n_r, n_nxt, d_r, d_nxt, r_r, r_nxt, q_r, q_nxt;
  logic [PROD_W:0]   rs, rdiff;
  logic [6:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  assign rs    = {r_r, n_r[PROD_W-1]};
  assign rdiff = rs - {1'b0, d_r};

  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    r_nxt    = r_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      n_nxt   = n_r << 1;
      cnt_nxt = cnt_r + 7'd1;
      if (!rdiff[PROD_W]) begin
        r_nxt = rdiff[PROD_W-1:0];
        q_nxt = {q_r[PROD_W-2:0], 1'b1};
      end else begin
        r_nxt = rs[PROD_W-1:0];
        q_nxt = {q_r[PROD_W-2:0], 1'b0};
      end
      if (cnt_r == 7'(PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      n_nxt    = num;
      d_nxt    = den;
      r_nxt    = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    r_r   <= r_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
